/* design/cvfs_pkg.sv */
// Shared types, codes and limits for the command validate / fence sequencer.
// No dependencies; every other design file imports this package.
package cvfs_pkg;

  localparam int ENGINE_COUNT   = 2;
  localparam int ENG_W          = 1;
  localparam int COPY_WORDS_MAX = 16;
  localparam logic [31:0] COPY_BYTES_MAX = 32'(COPY_WORDS_MAX * 4);
  localparam logic [31:0] DWORD_BYTES    = 32'd4;

  // command codes
  localparam logic CMD_SUBMIT  = 1'b0;
  localparam logic CMD_RECOVER = 1'b1;

  // opcodes
  localparam logic [1:0] OP_COPY  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;

  // buffer status codes
  localparam logic [1:0] BUF_ABSENT   = 2'd0;
  localparam logic [1:0] BUF_UNPLACED = 2'd1;
  localparam logic [1:0] BUF_UNMAPPED = 2'd2;
  localparam logic [1:0] BUF_MAPPED   = 2'd3;

  // result status codes
  localparam logic [2:0] ST_DONE       = 3'd0;
  localparam logic [2:0] ST_DISABLED   = 3'd1;
  localparam logic [2:0] ST_INVALID    = 3'd2;
  localparam logic [2:0] ST_FAULTED    = 3'd3;
  localparam logic [2:0] ST_EXEC_FAULT = 3'd4;

  typedef struct packed {
    logic        cmd;
    logic [1:0]  engine;
    logic [1:0]  opcode;
    logic [1:0]  src_status;
    logic [1:0]  dst_status;
    logic [31:0] length_bytes;
    logic [63:0] src_off;
    logic [63:0] dst_off;
    logic [63:0] src_buffer_bytes;
    logic [63:0] dst_buffer_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] sequence_res;
    logic [63:0] last_done_seq;
    logic [31:0] submitted_count;
    logic [31:0] recovered_count;
    logic        engine_faulted;
  } out_item_t;

  // validation verdict handed from the checker to the engine state
  typedef struct packed {
    logic eng_ok;
    logic sub_ok;
    logic mapped;
  } chk_t;

endpackage

/* design/cvfs_in_if.sv */
// Command input channel: valid/ready plus one command item.
// Depends on cvfs_pkg.
interface cvfs_in_if import cvfs_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/cvfs_out_if.sv */
// Result output channel: valid/ready plus one result item.
// Depends on cvfs_pkg.
interface cvfs_out_if import cvfs_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/cvfs_cfg_if.sv */
// Configuration write channel: valid/ready plus the enable bit.
// Depends on cvfs_pkg only through the shared import convention.
interface cvfs_cfg_if import cvfs_pkg::*; ();
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/cvfs_check.sv */
// Stateless validation of one command: engine range, opcode, buffer
// status, span checks with overflow guard, and mapping. Uses cvfs_pkg.
module cvfs_check import cvfs_pkg::*; (
  input  in_item_t item,
  output chk_t     chk
);

  logic [64:0] src_sum;
  logic [64:0] dst_sum;
  logic [64:0] wr_sum;
  logic        src_span_ok;
  logic        dst_span_ok;
  logic        wr_span_ok;
  logic        copy_ok;
  logic        write_ok;

  always_comb begin
    // carry out of the 65-bit sum is the overflow guard
    src_sum = {1'b0, item.src_off} + {33'd0, item.length_bytes};
    dst_sum = {1'b0, item.dst_off} + {33'd0, item.length_bytes};
    wr_sum  = {1'b0, item.dst_off} + {33'd0, DWORD_BYTES};

    src_span_ok = (item.length_bytes != 32'd0) && !src_sum[64] &&
                  (src_sum[63:0] <= item.src_buffer_bytes);
    dst_span_ok = (item.length_bytes != 32'd0) && !dst_sum[64] &&
                  (dst_sum[63:0] <= item.dst_buffer_bytes);
    wr_span_ok  = !wr_sum[64] && (wr_sum[63:0] <= item.dst_buffer_bytes);

    copy_ok  = (item.opcode == OP_COPY) &&
               (item.src_status >= BUF_UNMAPPED) &&
               (item.dst_status >= BUF_UNMAPPED) &&
               (item.length_bytes <= COPY_BYTES_MAX) &&
               src_span_ok && dst_span_ok;
    write_ok = (item.opcode == OP_WRITE) &&
               (item.dst_status >= BUF_UNMAPPED) &&
               (item.src_status == BUF_ABSENT) &&
               (item.length_bytes == DWORD_BYTES) &&
               (item.dst_off[1:0] == 2'd0) && wr_span_ok;

    chk.eng_ok = (int'(item.engine) < ENGINE_COUNT);
    if (item.engine[ENG_W-1:0] == 1'b0) begin
      chk.sub_ok = copy_ok;
      chk.mapped = (item.dst_status == BUF_MAPPED) && (item.src_status == BUF_MAPPED);
    end else begin
      chk.sub_ok = write_ok;
      chk.mapped = (item.dst_status == BUF_MAPPED);
    end
  end

endmodule

/* design/cvfs_engine.sv */
// Per-engine sequence, completion, counter and fault state with the
// update rule for one command; the result is produced combinationally.
// Uses cvfs_pkg.
module cvfs_engine import cvfs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  logic      enabled,
  input  in_item_t  item,
  input  chk_t      chk,
  output out_item_t res
);

  logic [63:0] next_seq_r [ENGINE_COUNT];
  logic [63:0] done_seq_r [ENGINE_COUNT];
  logic [31:0] acc_r      [ENGINE_COUNT];
  logic [31:0] rec_r      [ENGINE_COUNT];
  logic        fault_r    [ENGINE_COUNT];

  logic [ENG_W-1:0] e;
  logic [63:0]      next_seq_nxt;
  logic [63:0]      done_seq_nxt;
  logic [31:0]      acc_nxt;
  logic [31:0]      rec_nxt;
  logic             fault_nxt;
  logic [63:0]      seq;
  logic [2:0]       status;
  logic             upd;

  assign e = item.engine[ENG_W-1:0];

  always_comb begin
    next_seq_nxt = next_seq_r[e];
    done_seq_nxt = done_seq_r[e];
    acc_nxt      = acc_r[e];
    rec_nxt      = rec_r[e];
    fault_nxt    = fault_r[e];
    seq          = 64'd0;
    status       = ST_INVALID;
    upd          = 1'b0;
    res          = '0;
    res.status   = ST_INVALID;
    if (chk.eng_ok) begin
      upd = step;
      priority if (item.cmd == CMD_RECOVER) begin
        // recover is not gated by the enable bit
        fault_nxt = 1'b0;
        rec_nxt   = rec_r[e] + 32'd1;
        status    = ST_DONE;
      end else if (!enabled) begin
        status = ST_DISABLED;
      end else if (!chk.sub_ok) begin
        status = ST_INVALID;
      end else if (fault_r[e]) begin
        status = ST_FAULTED;
      end else begin
        seq          = next_seq_r[e] + 64'd1;
        next_seq_nxt = seq;
        done_seq_nxt = seq;
        acc_nxt      = acc_r[e] + 32'd1;
        if (chk.mapped) begin
          status = ST_DONE;
        end else begin
          fault_nxt = 1'b1;
          status    = ST_EXEC_FAULT;
        end
      end
      res.status          = status;
      res.sequence_res    = seq;
      res.last_done_seq   = done_seq_nxt;
      res.submitted_count = acc_nxt;
      res.recovered_count = rec_nxt;
      res.engine_faulted  = fault_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < ENGINE_COUNT; i++) begin
        next_seq_r[i] <= 64'd0;
        done_seq_r[i] <= 64'd0;
        acc_r[i]      <= 32'd0;
        rec_r[i]      <= 32'd0;
        fault_r[i]    <= 1'b0;
      end
    end else if (upd) begin
      next_seq_r[e] <= next_seq_nxt;
      done_seq_r[e] <= done_seq_nxt;
      acc_r[e]      <= acc_nxt;
      rec_r[e]      <= rec_nxt;
      fault_r[e]    <= fault_nxt;
    end
  end

endmodule

/* design/command_validate_fence_sequencer.sv */
// Top level of the command validate / fence sequencer: input register,
// checker, engine state and result register. Uses cvfs_pkg and the
// cvfs_in_if, cvfs_out_if and cvfs_cfg_if channel interfaces.
//
// Each command beat is validated and sequenced in a single pass: it is
// registered in the input register on acceptance, then checked and
// applied to its engine's state once the result register can take it,
// and the result is written into the result register with that state
// update. Throughput is one command per cycle while the result is not
// stalled. An input beat is taken while a result waits only if the
// input register is empty, and in_ch.ready drops only when both the
// input register and the result register are full and the result is
// stalled. Config writes are taken every cycle; the enable bit gates
// submits only, and recover does not depend on it.
module command_validate_fence_sequencer import cvfs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  cvfs_in_if.sink    in_ch,
  cvfs_out_if.source out_ch,
  cvfs_cfg_if.sink   cfg_ch
);

  in_item_t  s1_r;
  logic      s1_valid_r;
  logic      s1_valid_nxt;
  out_item_t out_r;
  logic      out_valid_r;
  logic      out_valid_nxt;
  logic      enabled_r;
  logic      adv;
  logic      step;
  logic      in_acc;
  chk_t      chk;
  out_item_t res;

  assign adv    = !out_valid_r || out_ch.ready;
  assign step   = s1_valid_r && adv;
  assign in_acc = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s1_valid_r || adv;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  cvfs_check u_check (
    .item (s1_r),
    .chk  (chk)
  );

  cvfs_engine u_engine (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .enabled (enabled_r),
    .item    (s1_r),
    .chk     (chk),
    .res     (res)
  );

  always_comb begin
    s1_valid_nxt = in_acc ? 1'b1 : (step ? 1'b0 : s1_valid_r);
    out_valid_nxt = step ? 1'b1 : (out_ch.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      enabled_r   <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        enabled_r <= cfg_ch.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_r <= in_ch.data;
    end
    if (step) begin
      out_r <= res;
    end
  end

  // an execution fault always leaves the engine faulted
  a_exec_fault_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == ST_EXEC_FAULT) |-> out_r.engine_faulted)
    else $error("execution fault reported without fault flag");

  // a faulted rejection takes no sequence and keeps the fault
  a_faulted_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_r.status == ST_FAULTED) |->
      out_r.engine_faulted && (out_r.sequence_res == 64'd0))
    else $error("faulted rejection consumed a sequence or lost the fault");

  // input backpressure only when both stages are full and output stalls
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> s1_valid_r && out_valid_r && !out_ch.ready)
    else $error("input stalled without a full pipeline");

endmodule
